>>> rtl/core/aie_pkg.sv
// Shared constants and types of the arithmetic interval encoder.
package aie_pkg;

  localparam int unsigned DefSymbolCount  = 256;
  localparam int unsigned DefProbFracBits = 16;

  localparam int unsigned CodeW  = 33;
  localparam int unsigned SymW   = 8;
  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 64;

  localparam logic [CodeW-1:0] TopReset = 33'h1_0000_0000;

  // opcode field
  localparam logic OpLoad   = 1'b0;
  localparam logic OpEncode = 1'b1;

  // register index, taken from paddr[3]
  localparam logic RegIntervalTop = 1'b0;

  // encode request into the narrowing unit
  typedef struct packed {
    logic valid;
    logic known;
    logic msg_end;
  } aie_req_t;

  // result item out of the narrowing unit
  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] code_value;
    logic             unknown_symbol;
    logic             code_valid;
  } aie_res_t;

endpackage

>>> rtl/core/aie_narrow.sv
// Interval narrowing unit: range multiply, interval update and code midpoint.
module aie_narrow import aie_pkg::*; #(
  parameter int unsigned PROB_FRAC_BITS = DefProbFracBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  aie_req_t                  req_i,
  input  logic [PROB_FRAC_BITS:0]   bound_lo_i,
  input  logic [PROB_FRAC_BITS:0]   bound_hi_i,
  input  logic                      top_wr_i,
  input  logic [CodeW-1:0]          top_i,
  output aie_res_t                  res_o,
  output logic                      busy_o
);

  localparam int unsigned ProbW = PROB_FRAC_BITS + 1;
  localparam int unsigned ProdW = CodeW + ProbW;
  localparam int unsigned OffW  = CodeW + 1;
  localparam int unsigned MidW  = CodeW + 3;

  logic [CodeW-1:0] low_q, high_q;
  logic [CodeW-1:0] range;
  logic [ProdW-1:0] prod_lo_d, prod_hi_d, prod_lo_q, prod_hi_q;
  logic             s2_valid_q, s2_end_q, s2_unknown_q;
  logic [OffW-1:0]  off_lo, off_hi;
  logic [CodeW-1:0] new_lo, new_hi;
  logic [MidW-1:0]  mid_sum;

  // stage 1: scale the range by both bounds; an unknown symbol keeps the interval
  assign range = high_q - low_q;

  always_comb begin
    if (req_i.known) begin
      prod_lo_d = ProdW'(range) * ProdW'(bound_lo_i);
      prod_hi_d = ProdW'(range) * ProdW'(bound_hi_i);
    end else begin
      prod_lo_d = '0;
      prod_hi_d = {1'b0, range, {PROB_FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      prod_lo_q    <= prod_lo_d;
      prod_hi_q    <= prod_hi_d;
      s2_end_q     <= req_i.msg_end;
      s2_unknown_q <= !req_i.known;
    end
  end

  // stage 2: new bounds and midpoint of the new interval
  assign off_lo  = prod_lo_q[ProdW-1:PROB_FRAC_BITS];
  assign off_hi  = prod_hi_q[ProdW-1:PROB_FRAC_BITS];
  assign new_lo  = CodeW'({1'b0, low_q} + off_lo);
  assign new_hi  = CodeW'({1'b0, low_q} + off_hi);
  assign mid_sum = MidW'({low_q, 1'b0}) + MidW'(off_lo) + MidW'(off_hi);

  // interval registers; a message end or a top write restarts at [0, top)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= TopReset;
    end else if (top_wr_i || (s2_valid_q && s2_end_q)) begin
      low_q  <= '0;
      high_q <= top_i;
    end else if (s2_valid_q) begin
      low_q  <= new_lo;
      high_q <= new_hi;
    end
  end

  // result: message end, or unknown symbol mid-message
  always_comb begin
    res_o.valid          = s2_valid_q && (s2_end_q || s2_unknown_q);
    res_o.code_value     = s2_end_q ? mid_sum[CodeW:1] : '0;
    res_o.unknown_symbol = s2_unknown_q;
    res_o.code_valid     = s2_end_q;
  end

  assign busy_o = s2_valid_q;

endmodule

>>> rtl/core/arith_interval_encoder.sv
// Arithmetic interval encoder: table load, bound memory, result queue.
// A result passes the stage 1 registers, the narrowing stage 2 registers and the result queue.
// An encode item is not accepted while the previous one is in stage 1, so the interval update loop
//   (bound memory read, range multiply, add back into low/high) closes first; loads are accepted
//   every cycle while not stalled. Input stalls while the result queue has no room for results in flight.
// Reset: control, sum, known map clear; interval [0, 2^32); bound memory not cleared.
module arith_interval_encoder import aie_pkg::*; #(
  parameter int unsigned SYMBOL_COUNT   = DefSymbolCount,
  parameter int unsigned PROB_FRAC_BITS = DefProbFracBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input items
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    opcode_i,
  input  logic                    table_restart_i,
  input  logic [SymW-1:0]         entry_symbol_i,
  input  logic [PROB_FRAC_BITS:0] entry_probability_i,
  input  logic [SymW-1:0]         code_symbol_i,
  input  logic                    message_end_i,
  // result items
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [CodeW-1:0]        code_value_o,
  output logic                    unknown_symbol_o,
  output logic                    code_valid_o,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PaddrW-1:0]       paddr,
  input  logic [PdataW-1:0]       pwdata,
  output logic [PdataW-1:0]       prdata,
  output logic                    pready
);

  localparam int unsigned StoreDepth = (SYMBOL_COUNT < 256) ? SYMBOL_COUNT : 256;
  localparam int unsigned IdxW       = $clog2(StoreDepth);
  localparam int unsigned ProbW      = PROB_FRAC_BITS + 1;
  localparam logic [16:0] SymLimit   = 17'(SYMBOL_COUNT);
  localparam logic [ProbW-1:0] OneFixed = ProbW'(1) << PROB_FRAC_BITS;

  logic [CodeW-1:0]      top_q, top_d;
  logic                  top_wr;
  logic                  in_acc, load_acc, enc_acc;
  logic [ProbW-1:0]      sum_q, sum_d, sum_base;
  logic [ProbW:0]        sum_ext;
  logic [StoreDepth-1:0] known_q, known_d;
  logic                  ld_in_range, enc_in_range, enc_known, store_wr;
  logic [IdxW-1:0]       ld_idx, enc_idx;
  logic [2*ProbW-1:0]    bound_mem [StoreDepth];
  logic [2*ProbW-1:0]    bound_rd_q;
  logic                  s1_valid_q, s1_known_q, s1_end_q;
  aie_req_t              req;
  aie_res_t              res;
  logic                  narrow_busy;
  aie_res_t              fifo_q [2];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            count_q;
  logic                  push, pop;

  // configuration port; a write to the interval top register restarts the interval at the new top
  assign pready = 1'b1;
  assign top_wr = psel && penable && pwrite && (paddr[3] == RegIntervalTop);
  assign prdata = (paddr[3] == RegIntervalTop) ? PdataW'(top_q) : '0;
  assign top_d  = top_wr ? pwdata[CodeW-1:0] : top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= TopReset;
    end else begin
      top_q <= top_d;
    end
  end

  // input handshake: one encode in stage 1, and queue room for results in flight
  assign in_ready_o = !s1_valid_q && ((count_q + 2'(narrow_busy)) < 2'd2);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_acc   = in_acc && (opcode_i == OpLoad);
  assign enc_acc    = in_acc && (opcode_i == OpEncode);

  // table load: saturating running sum and known map
  assign ld_in_range = 17'(entry_symbol_i) < SymLimit;
  assign ld_idx      = entry_symbol_i[IdxW-1:0];
  assign sum_base    = table_restart_i ? '0 : sum_q;
  assign sum_ext     = {1'b0, sum_base} + {1'b0, entry_probability_i};
  assign sum_d       = (sum_ext > {1'b0, OneFixed}) ? OneFixed : sum_ext[ProbW-1:0];
  // first load of a symbol since restart keeps its bounds
  assign store_wr    = load_acc && ld_in_range && (table_restart_i || !known_q[ld_idx]);

  always_comb begin
    known_d = known_q;
    if (load_acc) begin
      if (table_restart_i) begin
        known_d = '0;
      end
      if (ld_in_range) begin
        known_d[ld_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      known_q <= '0;
    end else if (load_acc) begin
      sum_q   <= sum_d;
      known_q <= known_d;
    end
  end

  // bound memory: {high, low} per symbol, registered read
  assign enc_in_range = 17'(code_symbol_i) < SymLimit;
  assign enc_idx      = code_symbol_i[IdxW-1:0];
  assign enc_known    = enc_in_range && known_q[enc_idx];

  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      bound_mem[ld_idx] <= {sum_d, sum_base};
    end
    bound_rd_q <= bound_mem[enc_idx];
  end

  // stage 1 control of the encode item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= enc_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enc_acc) begin
      s1_known_q <= enc_known;
      s1_end_q   <= message_end_i;
    end
  end

  assign req.valid   = s1_valid_q;
  assign req.known   = s1_known_q;
  assign req.msg_end = s1_end_q;

  aie_narrow #(
    .PROB_FRAC_BITS(PROB_FRAC_BITS)
  ) u_narrow (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .bound_lo_i (bound_rd_q[ProbW-1:0]),
    .bound_hi_i (bound_rd_q[2*ProbW-1:ProbW]),
    .top_wr_i   (top_wr),
    .top_i      (top_d),
    .res_o      (res),
    .busy_o     (narrow_busy)
  );

  // two-entry result queue
  assign push = res.valid;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

  assign out_valid_o      = (count_q != 2'd0);
  assign code_value_o     = fifo_q[rd_ptr_q].code_value;
  assign unknown_symbol_o = fifo_q[rd_ptr_q].unknown_symbol;
  assign code_valid_o     = fifo_q[rd_ptr_q].code_valid;

endmodule
